[src/skt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and helpers for the streaming k-th largest tracker.
// No dependencies.
package skt_pkg;

  typedef logic signed [31:0] word_t;

  localparam int RankWidth = 7;
  localparam int GroupSize = 8;

  function automatic logic word_greater(input word_t a, input word_t b);
    word_greater = a > b;
  endfunction

endpackage

[src/streaming_kth_largest_tracker.sv]
`timescale 1ns / 1ps
// Top level: sorted cell row, fill count, rank register and result pipeline.
// Depends on skt_pkg and skt_cell.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------
//  input   | in_valid / in_ready   | value, last
//  output  | out_valid / out_ready | kth_value, enough
//  config  | cfg_we                | cfg_wdata (k_rank)
//
// One request per cycle while in_ready is high; each active cell at or past the insert point updates in the same cycle.
// out_valid rises once the last request of a set has passed through the a and b stages and the output
// register, through a registered selection tree over the row in groups of eight cells.
// Reset clears the fill count and pipeline and sets k_rank to 1; no clearing pass.
// Input stalls during reset and while the finished row is held by a blocked output.
module streaming_kth_largest_tracker #(
  parameter int MAX_RANK = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  skt_pkg::word_t                   value,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output skt_pkg::word_t                   kth_value,
  output logic                             enough,
  input  logic                             cfg_we,
  input  logic [skt_pkg::RankWidth-1:0]    cfg_wdata
);
  import skt_pkg::*;

  localparam int CW   = $clog2(MAX_RANK + 1);
  localparam int NGRP = (MAX_RANK + GroupSize - 1) / GroupSize;

  logic [RankWidth-1:0] k_rank;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_next;
  logic [CW-1:0]        k_eff;
  logic [CW-1:0]        cnt_c;
  logic [CW-1:0]        cnt_inc;
  logic                 in_acc;

  word_t vals     [MAX_RANK];
  word_t picks    [MAX_RANK];
  logic  gts      [MAX_RANK];
  word_t grp      [NGRP];
  word_t grp_next [NGRP];
  word_t grp_or;

  logic a_valid, b_valid;
  logic a_enough, b_enough;
  logic o_load, b_can_load;

  always_comb begin
    if (k_rank == '0) begin
      k_eff = CW'(1);
    end else if (32'(k_rank) > 32'(MAX_RANK)) begin
      k_eff = CW'(MAX_RANK);
    end else begin
      k_eff = CW'(k_rank);
    end
  end

  assign cnt_c   = (cnt > k_eff) ? k_eff : cnt;
  assign cnt_inc = (cnt_c < k_eff) ? cnt_c + CW'(1) : cnt_c;

  assign o_load     = !out_valid || out_ready;
  assign b_can_load = !b_valid || o_load;
  assign in_ready   = !rst && !(a_valid && !b_can_load);
  assign in_acc     = in_valid && in_ready;

  genvar i;
  generate
    for (i = 0; i < MAX_RANK; i++) begin : g_cell
      word_t pv;
      logic  pg;
      if (i == 0) begin : g_head
        assign pv = '0;
        assign pg = 1'b0;
      end else begin : g_link
        assign pv = vals[i-1];
        assign pg = gts[i-1];
      end
      skt_cell #(
        .IDX(i),
        .CW (CW)
      ) u_cell (
        .clk     (clk),
        .upd     (in_acc),
        .din     (value),
        .prev_val(pv),
        .prev_gt (pg),
        .count   (cnt_c),
        .rank    (k_eff),
        .val     (vals[i]),
        .gt      (gts[i]),
        .pick    (picks[i])
      );
    end
  endgenerate

  always_comb begin
    cnt_next = cnt;
    if (in_acc) begin
      cnt_next = last ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_rank <= RankWidth'(1);
    end else if (cfg_we) begin
      k_rank <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      a_valid   <= (in_acc && last) || (a_valid && !b_can_load);
      b_valid   <= (a_valid && b_can_load) || (b_valid && !o_load);
      out_valid <= (b_valid && o_load) || (out_valid && !out_ready);
    end
  end

  always_comb begin
    for (int j = 0; j < NGRP; j++) begin
      grp_next[j] = '0;
      for (int b = 0; b < GroupSize; b++) begin
        if (j * GroupSize + b < MAX_RANK) begin
          grp_next[j] = grp_next[j] | picks[j * GroupSize + b];
        end
      end
    end
  end

  // hold the set's flag and selected group words as the row moves on
  always_ff @(posedge clk) begin
    if (in_acc && last) begin
      a_enough <= cnt_inc == k_eff;
    end
    if (a_valid && b_can_load) begin
      b_enough <= a_enough;
      grp      <= grp_next;
    end
    if (b_valid && o_load) begin
      enough    <= b_enough;
      kth_value <= b_enough ? grp_or : '0;
    end
  end

  always_comb begin
    grp_or = '0;
    for (int j = 0; j < NGRP; j++) begin
      grp_or = grp_or | grp[j];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_RANK))
    else $error("fill count above row length");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> cnt == '0 && a_valid)
    else $error("last request did not close the set");

  a_hold_row: assert property (@(posedge clk) disable iff (rst)
    a_valid && b_valid && out_valid && !out_ready |-> !in_ready)
    else $error("request taken while finished row is held");

  a_result_flow: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_valid |=> b_valid)
    else $error("selection stage did not advance");

endmodule

[src/skt_cell.sv]
`timescale 1ns / 1ps
// One position of the sorted row, largest value at position zero.
// Depends on skt_pkg.
module skt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic          clk,
  input  logic          upd,
  input  skt_pkg::word_t din,
  input  skt_pkg::word_t prev_val,
  input  logic          prev_gt,
  input  logic [CW-1:0] count,
  input  logic [CW-1:0] rank,
  output skt_pkg::word_t val,
  output logic          gt,
  output skt_pkg::word_t pick
);
  import skt_pkg::*;

  logic live;
  logic active;

  assign live   = CW'(IDX) < count;
  assign active = CW'(IDX) < rank;
  assign gt     = !live || word_greater(din, val);
  assign pick   = (CW'(IDX + 1) == rank) ? val : '0;

  // take the new value at the insert point, shift in from the left above it
  always_ff @(posedge clk) begin
    if (upd && active && gt) begin
      val <= prev_gt ? prev_val : din;
    end
  end

endmodule
